// ----- rtl/core/response_deframer_crc16_check_top_defines.svh -----
// assertion macros for the response deframer rtl
// used by response_deframer_crc16_check_top; expects clk_i and rst_ni in scope
`ifndef RESPONSE_DEFRAMER_CRC16_CHECK_TOP_DEFINES_SVH
`define RESPONSE_DEFRAMER_CRC16_CHECK_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define RDFC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rdfc assertion failed");

`define RDFC_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`else

`define RDFC_ASSERT(label, prop)

`define RDFC_ASSERT_MSG(label, prop, msg)

`endif

`endif

// ----- rtl/core/rdfc_pkg.sv -----
// shared types, constants and the crc-16 byte update for the response deframer
// no dependencies; imported by rdfc_frame_engine and the top level
package rdfc_pkg;

  localparam int MaxFrameBytes = 256;
  localparam int PosW          = $clog2(MaxFrameBytes + 1);
  localparam int MinFrame      = 5;

  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [7:0]  FrameOpen = 8'h28;
  localparam logic [7:0]  FrameCr   = 8'h0D;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_TERM  = 3'd3,
    ST_CRC_ERR   = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_e;

  typedef struct packed {
    logic       has_item;
    logic [7:0] body_byte;
    logic       body_valid;
    logic       frame_end;
    status_e    status;
    logic [7:0] body_length;
  } rdfc_result_t;

  // msb-first crc-16, one byte, unrolled over eight bit steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/rdfc_frame_engine.sv -----
// frame state: three-byte delay line, position, running crc and verdict logic
// depends on rdfc_pkg
module rdfc_frame_engine import rdfc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   data_i,
  input  logic         last_i,
  output rdfc_result_t result_o
);

  logic [7:0]      delay_q [3];
  logic [7:0]      delay_d [3];
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic            start_q, start_d;
  logic [7:0]      count_q, count_d;

  logic            start_now;
  logic            feed;
  logic            emit;
  logic [15:0]     crc_now;
  logic [7:0]      count_now;
  logic [15:0]     crc_got;
  status_e         verdict;

  always_comb begin
    start_now = (pos_q == '0) ? (data_i == FrameOpen) : start_q;
    feed      = pos_q >= PosW'(3);
    emit      = (pos_q >= PosW'(4)) && (pos_q <= PosW'(MaxFrameBytes - 1)) && start_now;
    crc_now   = feed ? crc_feed(crc_q, delay_q[2]) : crc_q;
    count_now = (emit && count_q != 8'hFF) ? count_q + 8'd1 : count_q;
    // trailer sits in the two newest bytes: crc high then crc low
    crc_got   = {delay_q[1], delay_q[0]};

    if (pos_q < PosW'(MinFrame - 1)) begin
      verdict = ST_SHORT;
    end else if (!start_now) begin
      verdict = ST_BAD_START;
    end else if (data_i != FrameCr) begin
      verdict = ST_BAD_TERM;
    end else if (pos_q >= PosW'(MaxFrameBytes)) begin
      verdict = ST_TOO_LONG;
    end else if (crc_got != crc_now) begin
      verdict = ST_CRC_ERR;
    end else begin
      verdict = ST_OK;
    end

    result_o.has_item    = emit || last_i;
    result_o.body_byte   = emit ? delay_q[2] : 8'h00;
    result_o.body_valid  = emit;
    result_o.frame_end   = last_i;
    result_o.status      = last_i ? verdict : ST_OK;
    result_o.body_length = last_i ? count_now : 8'h00;
  end

  always_comb begin
    delay_d = delay_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    start_d = start_q;
    count_d = count_q;
    if (step_i) begin
      if (last_i) begin
        delay_d = '{default: 8'h00};
        pos_d   = '0;
        crc_d   = '0;
        start_d = 1'b0;
        count_d = '0;
      end else begin
        delay_d[2] = delay_q[1];
        delay_d[1] = delay_q[0];
        delay_d[0] = data_i;
        if (pos_q < PosW'(MaxFrameBytes)) begin
          pos_d = pos_q + PosW'(1);
        end
        crc_d   = crc_now;
        start_d = start_now;
        count_d = count_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '{default: 8'h00};
      pos_q   <= '0;
      crc_q   <= '0;
      start_q <= 1'b0;
      count_q <= '0;
    end else begin
      delay_q <= delay_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      start_q <= start_d;
      count_q <= count_d;
    end
  end

endmodule

// ----- rtl/core/response_deframer_crc16_check_top.sv -----
// channel   | direction | tdata                                   | tuser      | tlast
// s_axis    | in        | [7:0] data_byte                         | -          | last_byte
// m_axis    | out       | [7:0] body_byte [10:8] frame_status     | body_valid | frame_end
//           |           | [18:11] body_length [23:19] zero        |            |
//
// one request per cycle sustained while results are taken; each request passes through
// the input register and then the result register around the frame engine
// a request that neither completes a body byte nor ends the frame gives no result
// a stalled result holds the engine; the input register still takes one request
// asynchronous active-low reset clears frame state and both valid flags
// depends on rdfc_pkg, rdfc_frame_engine and the assertion macro header
`include "response_deframer_crc16_check_top_defines.svh"

module response_deframer_crc16_check_top import rdfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] body_byte, [10:8] frame_status,
                                      // [18:11] body_length, [23:19] zero
  output logic        m_axis_tuser,   // [0] body_byte_valid
  output logic        m_axis_tlast
);

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_data_q, in_data_d;
  logic         in_last_q, in_last_d;
  logic         out_valid_q, out_valid_d;
  rdfc_result_t out_q, out_d;
  rdfc_result_t result;
  logic         advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  rdfc_frame_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .data_i   (in_data_q),
    .last_i   (in_last_q),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    in_data_d  = in_data_q;
    in_last_d  = in_last_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
      in_data_d  = s_axis_tdata;
      in_last_d  = s_axis_tlast;
    end

    out_d = out_q;
    if (advance) begin
      out_valid_d = result.has_item;
      out_d       = result;
    end else begin
      out_valid_d = out_valid_q && !m_axis_tready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_data_q <= in_data_d;
    in_last_q <= in_last_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.body_length, out_q.status, out_q.body_byte};
  assign m_axis_tuser  = out_q.body_valid;
  assign m_axis_tlast  = out_q.frame_end;

  // a result always carries a body byte or a verdict
  `RDFC_ASSERT(a_result_has_content, m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
  // verdict fields stay zero away from the frame end
  `RDFC_ASSERT_MSG(a_idle_verdict_zero,
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[18:8] == 11'd0),
    "verdict fields set on a mid-frame result")
  // full input register behind a stalled result must block new requests
  `RDFC_ASSERT(a_stall_blocks_input,
    (out_valid_q && !m_axis_tready && in_valid_q) |-> !s_axis_tready)
  // status code stays within the defined set
  `RDFC_ASSERT(a_status_range,
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[10:8] <= 3'd5))

endmodule

// ----- tb/sv/tb_response_deframer_crc16_check_top.sv -----
// self-checking testbench for response_deframer_crc16_check_top
// predicts body bytes, status and length per request; depends on rdfc_pkg and the top level rtl
`timescale 1ns / 100ps

module tb_response_deframer_crc16_check_top;
  import rdfc_pkg::*;

  localparam int ClkPeriod     = 8;
  localparam int RandomItems   = 1780;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 10;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_TERM, FR_BAD_START, FR_SHORT, FR_NOISE} frame_kind_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } rx_byte_t;

  typedef struct packed {
    logic [4:0] pad;
    logic [7:0] blen;
    status_e    status;
    logic       fend;
    logic       bvalid;
    logic [7:0] body;
  } deframe_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  response_deframer_crc16_check_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  rx_byte_t     frame_byte_q[$];
  deframe_out_t deframed_q[$];

  // predictor state of one frame
  logic [7:0]  win_bytes[3];
  int unsigned rx_pos;
  logic [15:0] crc_acc;
  logic        open_ok;
  int unsigned body_count;

  int   error_count;
  int   accepted_count;
  int   total_items;
  int   idle_cycles;
  bit   req_taken;
  bit   resp_taken;
  bit   src_burst;
  bit   sink_burst;
  int   src_gap;
  int   sink_stall;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // bitwise msb-first crc, poly from the package
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  task automatic clear_frame_state();
    win_bytes[0] = '0;
    win_bytes[1] = '0;
    win_bytes[2] = '0;
    rx_pos       = 0;
    crc_acc      = '0;
    open_ok      = 1'b0;
    body_count   = 0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic last);
    deframe_out_t r;
    logic [7:0]   leaving;
    logic [15:0]  got_crc;
    r        = '0;
    r.status = ST_OK;
    leaving  = win_bytes[2];
    if (rx_pos == 0) begin
      open_ok = (b == FrameOpen);
    end
    // the byte leaving the window can no longer belong to the trailer
    if (rx_pos >= 3) begin
      crc_acc = crc16_next(crc_acc, leaving);
      if (rx_pos >= 4 && rx_pos <= MaxFrameBytes - 1 && open_ok) begin
        r.body   = leaving;
        r.bvalid = 1'b1;
        body_count++;
      end
    end
    if (last) begin
      got_crc = {win_bytes[1], win_bytes[0]};
      r.fend  = 1'b1;
      if (rx_pos + 1 < MinFrame) begin
        r.status = ST_SHORT;
      end else if (!open_ok) begin
        r.status = ST_BAD_START;
      end else if (b != FrameCr) begin
        r.status = ST_BAD_TERM;
      end else if (rx_pos >= MaxFrameBytes) begin
        r.status = ST_TOO_LONG;
      end else if (got_crc != crc_acc) begin
        r.status = ST_CRC_ERR;
      end
      r.blen = (body_count > 255) ? 8'd255 : 8'(body_count);
      clear_frame_state();
    end else begin
      win_bytes[2] = win_bytes[1];
      win_bytes[1] = win_bytes[0];
      win_bytes[0] = b;
      if (rx_pos < MaxFrameBytes) begin
        rx_pos++;
      end
    end
    if (r.bvalid || r.fend) begin
      deframed_q.push_back(r);
    end
  endtask

  // for short and noise frames len is the total byte count, otherwise the body length
  task automatic add_frame(input frame_kind_e kind, input int len, input int fill);
    logic [7:0]  fb[$];
    logic [7:0]  b;
    logic [15:0] crc;
    rx_byte_t    item;
    crc = '0;
    case (kind) inside
      FR_SHORT, FR_NOISE: begin
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom_range(0, 255));
          if (i == 0 && $urandom_range(0, 1)) begin
            b = FrameOpen;
          end
          fb.push_back(b);
        end
      end
      default: begin
        if (kind == FR_BAD_START) begin
          do b = 8'($urandom_range(0, 255)); while (b == FrameOpen);
        end else begin
          b = FrameOpen;
        end
        fb.push_back(b);
        for (int i = 0; i < len; i++) begin
          fb.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
        end
        foreach (fb[i]) begin
          crc = crc16_next(crc, fb[i]);
        end
        if (kind == FR_BAD_CRC) begin
          crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        fb.push_back(crc[15:8]);
        fb.push_back(crc[7:0]);
        if (kind == FR_BAD_TERM) begin
          do b = 8'($urandom_range(0, 255)); while (b == FrameCr);
        end else begin
          b = FrameCr;
        end
        fb.push_back(b);
      end
    endcase
    foreach (fb[i]) begin
      item.data = fb[i];
      item.last = (i == fb.size() - 1);
      frame_byte_q.push_back(item);
    end
  endtask

  // stimulus and end of run
  initial begin
    int sel;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    error_count   = 0;
    accepted_count = 0;
    idle_cycles   = 0;
    req_taken     = 1'b0;
    resp_taken    = 1'b0;
    src_burst     = 1'b0;
    sink_burst    = 1'b0;
    src_gap       = $urandom_range(0, 5);
    sink_stall    = $urandom_range(0, 5);
    clear_frame_state();

    // directed: shortest frames, extreme body values, short, bad-start, bad-term and crc-error verdicts
    add_frame(FR_SHORT, 1, -1);
    add_frame(FR_SHORT, 4, -1);
    add_frame(FR_GOOD, 1, 8'h00);
    add_frame(FR_GOOD, 1, 8'hFF);
    add_frame(FR_BAD_START, 1, -1);
    add_frame(FR_BAD_TERM, 1, -1);
    add_frame(FR_BAD_CRC, 1, -1);

    while (frame_byte_q.size() < RandomItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 57) begin
        add_frame(FR_GOOD, $urandom_range(0, 24), -1);
      end else if (sel < 67) begin
        add_frame(FR_BAD_CRC, $urandom_range(0, 24), -1);
      end else if (sel < 75) begin
        add_frame(FR_BAD_TERM, $urandom_range(0, 24), -1);
      end else if (sel < 82) begin
        add_frame(FR_BAD_START, $urandom_range(0, 24), -1);
      end else if (sel < 89) begin
        add_frame(FR_SHORT, $urandom_range(1, 4), -1);
      end else if (sel < 97) begin
        add_frame(FR_NOISE, $urandom_range(1, 10), -1);
      end else begin
        // around the frame size limit, some well past it
        add_frame($urandom_range(0, 3) ? FR_GOOD : FR_BAD_CRC, $urandom_range(248, 300), -1);
      end
    end
    total_items = frame_byte_q.size();

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(accepted_count == total_items && deframed_q.size() == 0)) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // request driver
  always @(negedge clk_i) begin : req_drive
    logic     nv;
    rx_byte_t item;
    if (rst_ni) begin
      nv = s_axis_tvalid;
      if (req_taken) begin
        req_taken = 1'b0;
        nv = 1'b0;
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (frame_byte_q.size() > 0) begin
          item = frame_byte_q.pop_front();
          s_axis_tdata <= item.data;
          s_axis_tlast <= item.last;
          nv = 1'b1;
          if ($urandom_range(0, 39) == 0) begin
            src_burst = !src_burst;
          end
          src_gap = src_burst ? 0 : $urandom_range(0, 5);
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // result sink backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (resp_taken) begin
        resp_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) begin
          sink_burst = !sink_burst;
        end
        sink_stall = sink_burst ? 0 : $urandom_range(0, 5);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin : monitor
    deframe_out_t act;
    deframe_out_t exp;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata, s_axis_tlast);
        req_taken = 1'b1;
        accepted_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        resp_taken = 1'b1;
        act.body   = m_axis_tdata[7:0];
        act.status = status_e'(m_axis_tdata[10:8]);
        act.blen   = m_axis_tdata[18:11];
        act.pad    = m_axis_tdata[23:19];
        act.bvalid = m_axis_tuser;
        act.fend   = m_axis_tlast;
        if (deframed_q.size() == 0) begin
          $display("%0t: unexpected result body=%02h vld=%0b end=%0b st=%0d len=%0d",
                   $realtime, act.body, act.bvalid, act.fend, act.status, act.blen);
          error_count++;
        end else begin
          exp = deframed_q.pop_front();
          if (act !== exp) begin
            $display("%0t: mismatch exp body=%02h vld=%0b end=%0b st=%0d len=%0d pad=%0h",
                     $realtime, exp.body, exp.bvalid, exp.fend, exp.status, exp.blen, exp.pad);
            $display("%0t:          got body=%02h vld=%0b end=%0b st=%0d len=%0d pad=%0h",
                     $realtime, act.body, act.bvalid, act.fend, act.status, act.blen, act.pad);
            error_count++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d results outstanding", $realtime, deframed_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
